@@ rtl/core/imrs_pkg.sv @@
// ----------------------------------------------------------------------------
// imrs_pkg
// Shared types, constants and the Catmull-Rom weight function of the scaler.
// ----------------------------------------------------------------------------
package imrs_pkg;

  localparam int DVD_W = 25;
  localparam int DVS_W = 13;
  localparam int POS_W = 25;
  localparam int WGT_W = 18;

  localparam logic [2:0] REG_IN_WIDTH    = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_OUT_WIDTH   = 3'd2;
  localparam logic [2:0] REG_OUT_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_MAX_VALUE   = 3'd4;
  localparam logic [2:0] REG_FILTER_KIND = 3'd5;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EMIT = 1'b1;

  localparam logic FILTER_BILINEAR = 1'b0;
  localparam logic FILTER_BICUBIC  = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [1:0] i;
    logic [1:0] j;
    logic       last_i;
    logic       last;
  } tap_t;

  function automatic logic signed [WGT_W-1:0] cubic_weight(
    input logic [1:0]  k,
    input logic [15:0] u,
    input logic [31:0] u2,
    input logic [47:0] u3
  );
    logic signed [55:0] t1;
    logic signed [55:0] t2;
    logic signed [55:0] t3;
    logic signed [55:0] n;
    logic signed [55:0] r;
    t1 = $signed({8'd0, u, 32'd0});
    t2 = $signed({8'd0, u2, 16'd0});
    t3 = $signed({8'd0, u3});
    case (k)
      2'd0:    n = -t3 + (t2 + t2) - t1;
      2'd1:    n = (t3 + t3 + t3) - ((t2 <<< 2) + t2) + (56'sd1 <<< 49);
      2'd2:    n = -(t3 + t3 + t3) + (t2 <<< 2) + t1;
      default: n = t3 - t2;
    endcase
    r = (n + (56'sd1 <<< 32)) >>> 33;
    return r[WGT_W-1:0];
  endfunction

endpackage

@@ rtl/core/image_resize_bilinear_bicubic.sv @@
// ----------------------------------------------------------------------------
// image_resize_bilinear_bicubic
// Grey 16-bit image scaler with bilinear or Catmull-Rom bicubic filtering.
// ----------------------------------------------------------------------------
// A load item writes the next input pixel in raster order.
// An emit item produces the next output pixel: weight setup runs states S_WA,
// S_WB and S_WC for x and again for y, the frame-store port then reads one tap
// per cycle (16 taps bicubic, 4 bilinear) and the pipeline drains. The first
// emit after reset or after a write to any of registers 0 to 5 also runs two
// step divisions on the shared divider. Frame-store entries that were never
// loaded read as unknown data.
module image_resize_bilinear_bicubic #(
  parameter int MAX_IN_W    = 256,
  parameter int MAX_IN_H    = 256,
  parameter int MAX_OUT_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [15:0] pixel_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] pixel_out,
  output logic        end_of_row,
  output logic        end_of_frame
);

  localparam int IW_CAP = (MAX_IN_W > 511) ? 511 : MAX_IN_W;
  localparam int IH_CAP = (MAX_IN_H > 511) ? 511 : MAX_IN_H;
  localparam int OD_CAP = (MAX_OUT_DIM > 8191) ? 8191 : MAX_OUT_DIM;
  localparam int AW     = $clog2(IW_CAP * IH_CAP);
  localparam logic [8:0]  IW_CAP_V = 9'(IW_CAP);
  localparam logic [8:0]  IH_CAP_V = 9'(IH_CAP);
  localparam logic [12:0] OD_CAP_V = 13'(OD_CAP);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DXS   = 11'b00000000010,
    S_DXW   = 11'b00000000100,
    S_DYS   = 11'b00000001000,
    S_DYW   = 11'b00000010000,
    S_WA    = 11'b00000100000,
    S_WB    = 11'b00001000000,
    S_WC    = 11'b00010000000,
    S_TAP   = 11'b00100000000,
    S_DRAIN = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  logic [8:0]  in_width, in_height;
  logic [12:0] out_width, out_height;
  logic [15:0] max_value;
  logic        filter_kind;

  logic [8:0]  iw_eff, ih_eff;
  logic [12:0] ow_eff, oh_eff;

  logic [17:0] load_count;
  logic [12:0] out_col, out_row;
  logic [imrs_pkg::POS_W-1:0] xpos, ypos, xq, yq;
  logic [12:0] xrem, yrem, xr, yr;
  logic        step_ok;

  logic        div_start, div_done;
  logic [imrs_pkg::DVD_W-1:0] div_dvd, div_quot;
  logic [imrs_pkg::DVS_W-1:0] div_dvs, div_rem;

  logic        wsel;
  logic [31:0] m2;
  logic [47:0] m3;
  logic signed [imrs_pkg::WGT_W-1:0] wx [4];
  logic signed [imrs_pkg::WGT_W-1:0] wy [4];

  logic [1:0]  ti, tj, tlast;
  logic [AW-1:0] addr_r;
  imrs_pkg::tap_t tap_a, tap_b;
  logic [15:0] rdata;
  logic signed [63:0] mac_sum;
  logic        mac_done;

  logic [8:0]  ix, iy;
  logic        xlast, ylast;
  logic signed [10:0] xs, ys, xt, yt;
  logic [8:0]  xc, yc;
  logic [19:0] addr_full;
  logic [15:0] u;
  logic [16:0] f17;
  logic        bic;
  logic        eor, eof;
  logic [31:0] q;
  logic [15:0] res;
  logic        deliver;
  logic        load_acc;
  logic [17:0] total;
  logic [13:0] xs_sum, ys_sum;

  always_comb begin
    iw_eff = (in_width < 9'd4) ? 9'd4 : ((in_width > IW_CAP_V) ? IW_CAP_V : in_width);
    ih_eff = (in_height < 9'd4) ? 9'd4 : ((in_height > IH_CAP_V) ? IH_CAP_V : in_height);
    ow_eff = (out_width == 13'd0) ? 13'd1 : ((out_width > OD_CAP_V) ? OD_CAP_V : out_width);
    oh_eff = (out_height == 13'd0) ? 13'd1 : ((out_height > OD_CAP_V) ? OD_CAP_V : out_height);
  end

  assign bic   = filter_kind == imrs_pkg::FILTER_BICUBIC;
  assign tlast = bic ? 2'd3 : 2'd1;
  assign ix    = xpos[24:16];
  assign iy    = ypos[24:16];
  assign xlast = ix == iw_eff - 9'd1;
  assign ylast = iy == ih_eff - 9'd1;
  assign xs    = $signed({2'b00, ix}) - ((bic || xlast) ? 11'sd1 : 11'sd0);
  assign ys    = $signed({2'b00, iy}) - ((bic || ylast) ? 11'sd1 : 11'sd0);
  assign u     = wsel ? ypos[15:0] : xpos[15:0];
  assign f17   = wsel ? {ylast, ypos[15:0]} : {xlast, xpos[15:0]};

  always_comb begin
    xt = xs + $signed({9'd0, ti});
    yt = ys + $signed({9'd0, tj});
    if (xt < 0) begin
      xc = 9'd0;
    end else if (xt > $signed({2'b00, iw_eff - 9'd1})) begin
      xc = iw_eff - 9'd1;
    end else begin
      xc = xt[8:0];
    end
    if (yt < 0) begin
      yc = 9'd0;
    end else if (yt > $signed({2'b00, ih_eff - 9'd1})) begin
      yc = ih_eff - 9'd1;
    end else begin
      yc = yt[8:0];
    end
    addr_full = 20'(yc) * 20'(iw_eff) + {11'd0, xc};
  end

  assign eor = out_col == ow_eff - 13'd1;
  assign eof = eor && (out_row == oh_eff - 13'd1);
  assign q   = mac_sum[63:32];
  assign res = (mac_sum <= 0) ? 16'd0 : ((q > {16'd0, max_value}) ? max_value : q[15:0]);
  assign deliver  = (state == S_DONE) && (!out_valid || out_ready);
  assign in_ready = state == S_IDLE;
  assign load_acc = in_valid && in_ready && (mode == imrs_pkg::MODE_LOAD);
  assign total    = 18'(iw_eff) * 18'(ih_eff);
  assign xs_sum   = {1'b0, xrem} + {1'b0, xr};
  assign ys_sum   = {1'b0, yrem} + {1'b0, yr};

  assign div_start = (state == S_DXS) || (state == S_DYS);
  assign div_dvd   = (state == S_DXS) ? {iw_eff, 16'd0} : {ih_eff, 16'd0};
  assign div_dvs   = (state == S_DXS || state == S_DXW) ? ow_eff : oh_eff;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && mode == imrs_pkg::MODE_EMIT) begin
          state_next = step_ok ? S_WA : S_DXS;
        end
      end
      S_DXS:   state_next = S_DXW;
      S_DXW:   if (div_done) state_next = S_DYS;
      S_DYS:   state_next = S_DYW;
      S_DYW:   if (div_done) state_next = S_WA;
      S_WA:    state_next = S_WB;
      S_WB:    state_next = S_WC;
      S_WC:    state_next = wsel ? S_TAP : S_WA;
      S_TAP:   if (ti == tlast && tj == tlast) state_next = S_DRAIN;
      S_DRAIN: if (mac_done) state_next = S_DONE;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      in_width    <= 9'd256;
      in_height   <= 9'd256;
      out_width   <= 13'd256;
      out_height  <= 13'd256;
      max_value   <= 16'hFFFF;
      filter_kind <= imrs_pkg::FILTER_BICUBIC;
      load_count  <= '0;
      out_col     <= '0;
      out_row     <= '0;
      xpos        <= '0;
      ypos        <= '0;
      xrem        <= '0;
      yrem        <= '0;
      step_ok     <= 1'b0;
      wsel        <= 1'b0;
      ti          <= '0;
      tj          <= '0;
      tap_a       <= '0;
      tap_b       <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      tap_b <= tap_a;
      tap_a <= '0;
      if (cfg_write_en) begin
        unique case (cfg_index)
          imrs_pkg::REG_IN_WIDTH:    in_width    <= cfg_data[8:0];
          imrs_pkg::REG_IN_HEIGHT:   in_height   <= cfg_data[8:0];
          imrs_pkg::REG_OUT_WIDTH:   out_width   <= cfg_data[12:0];
          imrs_pkg::REG_OUT_HEIGHT:  out_height  <= cfg_data[12:0];
          imrs_pkg::REG_MAX_VALUE:   max_value   <= cfg_data;
          imrs_pkg::REG_FILTER_KIND: filter_kind <= cfg_data[0];
          default: ;
        endcase
        if (cfg_index <= imrs_pkg::REG_FILTER_KIND) begin
          load_count <= '0;
          out_col    <= '0;
          out_row    <= '0;
          xpos       <= '0;
          ypos       <= '0;
          xrem       <= '0;
          yrem       <= '0;
          step_ok    <= 1'b0;
        end
      end
      if (load_acc) begin
        load_count <= (load_count + 18'd1 >= total) ? 18'd0 : load_count + 18'd1;
      end
      if (state == S_DYW && div_done) begin
        step_ok <= 1'b1;
      end
      if (state == S_WC) begin
        wsel <= !wsel;
      end
      if (state == S_TAP) begin
        tap_a <= '{valid: 1'b1, i: ti, j: tj, last_i: ti == tlast,
                   last: (ti == tlast) && (tj == tlast)};
        if (ti == tlast) begin
          ti <= '0;
          tj <= (tj == tlast) ? 2'd0 : tj + 2'd1;
        end else begin
          ti <= ti + 2'd1;
        end
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (deliver) begin
        out_valid <= 1'b1;
        if (eor) begin
          out_col <= '0;
          xpos    <= '0;
          xrem    <= '0;
          if (eof) begin
            out_row <= '0;
            ypos    <= '0;
            yrem    <= '0;
          end else begin
            out_row <= out_row + 13'd1;
            if (ys_sum >= {1'b0, oh_eff}) begin
              yrem <= 13'(ys_sum - {1'b0, oh_eff});
              ypos <= ypos + yq + 25'd1;
            end else begin
              yrem <= ys_sum[12:0];
              ypos <= ypos + yq;
            end
          end
        end else begin
          out_col <= out_col + 13'd1;
          if (xs_sum >= {1'b0, ow_eff}) begin
            xrem <= 13'(xs_sum - {1'b0, ow_eff});
            xpos <= xpos + xq + 25'd1;
          end else begin
            xrem <= xs_sum[12:0];
            xpos <= xpos + xq;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DXW && div_done) begin
      xq <= div_quot;
      xr <= div_rem;
    end
    if (state == S_DYW && div_done) begin
      yq <= div_quot;
      yr <= div_rem;
    end
    if (state == S_WA) begin
      m2 <= u * u;
    end
    if (state == S_WB) begin
      m3 <= m2 * u;
    end
    if (state == S_WC) begin
      for (int k = 0; k < 4; k++) begin
        if (bic) begin
          if (wsel) begin
            wy[k] <= imrs_pkg::cubic_weight(2'(k), u, m2, m3);
          end else begin
            wx[k] <= imrs_pkg::cubic_weight(2'(k), u, m2, m3);
          end
        end else begin
          if (wsel) begin
            wy[k] <= (k == 0) ? 18'sd65536 - $signed({1'b0, f17}) :
                     ((k == 1) ? $signed({1'b0, f17}) : 18'sd0);
          end else begin
            wx[k] <= (k == 0) ? 18'sd65536 - $signed({1'b0, f17}) :
                     ((k == 1) ? $signed({1'b0, f17}) : 18'sd0);
          end
        end
      end
    end
    if (state == S_TAP) begin
      addr_r <= addr_full[AW-1:0];
    end
    if (deliver) begin
      pixel_out    <= res;
      end_of_row   <= eor;
      end_of_frame <= eof;
    end
  end

  imrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  imrs_store #(.AW(AW)) u_store (
    .clk   (clk),
    .we    (load_acc),
    .waddr (load_count[AW-1:0]),
    .wdata (pixel_in),
    .raddr (addr_r),
    .rdata (rdata)
  );

  imrs_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .tap  (tap_b),
    .pix  (rdata),
    .wx   (wx),
    .wy   (wy),
    .sum  (mac_sum),
    .done (mac_done)
  );

  a_mac_done_drain: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == S_DRAIN) else $error("mac result outside drain");

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == imrs_pkg::MODE_EMIT |=> !in_ready)
    else $error("emit item did not start a computation");

  a_eof_eor: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> end_of_row) else $error("frame end without row end");

  a_taps_step: assert property (@(posedge clk) disable iff (rst)
    state == S_TAP |-> step_ok) else $error("taps issued before step sizes");

endmodule

@@ rtl/core/imrs_div.sv @@
// ----------------------------------------------------------------------------
// imrs_div
// Restoring divider, one quotient bit per cycle, for the source step sizes.
// ----------------------------------------------------------------------------
module imrs_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [imrs_pkg::DVD_W-1:0]  dividend,
  input  logic [imrs_pkg::DVS_W-1:0]  divisor,
  output logic                        done,
  output logic [imrs_pkg::DVD_W-1:0]  quot,
  output logic [imrs_pkg::DVS_W-1:0]  rem
);

  localparam int CW = $clog2(imrs_pkg::DVD_W + 1);

  logic [imrs_pkg::DVS_W:0]   rem_r;
  logic [imrs_pkg::DVD_W-1:0] quo_r;
  logic [CW-1:0]              cnt;
  logic                       busy;
  logic [imrs_pkg::DVS_W:0]   rem_sh;
  logic [imrs_pkg::DVS_W:0]   rem_sub;
  logic                       fits;

  assign rem_sh  = {rem_r[imrs_pkg::DVS_W-1:0], quo_r[imrs_pkg::DVD_W-1]};
  assign fits    = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(imrs_pkg::DVD_W);
        rem_r <= '0;
        quo_r <= dividend;
      end else if (busy) begin
        rem_r <= fits ? rem_sub : rem_sh;
        quo_r <= {quo_r[imrs_pkg::DVD_W-2:0], fits};
        cnt   <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = quo_r;
  assign rem  = rem_r[imrs_pkg::DVS_W-1:0];

endmodule

@@ rtl/core/imrs_store.sv @@
// ----------------------------------------------------------------------------
// imrs_store
// Frame store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module imrs_store #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/imrs_mac.sv @@
// ----------------------------------------------------------------------------
// imrs_mac
// Multiply-accumulate unit: horizontal tap sums, then weighted row sums.
// ----------------------------------------------------------------------------
module imrs_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  imrs_pkg::tap_t                      tap,
  input  logic [15:0]                         pix,
  input  logic signed [imrs_pkg::WGT_W-1:0]   wx [4],
  input  logic signed [imrs_pkg::WGT_W-1:0]   wy [4],
  output logic signed [63:0]                  sum,
  output logic                                done
);

  logic signed [36:0] h_acc;
  logic signed [34:0] prod;
  logic signed [54:0] row_prod;
  logic               row_flag;
  logic               row_last;
  logic [1:0]         row_j;

  assign prod     = wx[tap.i] * $signed({1'b0, pix});
  assign row_prod = wy[row_j] * h_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_flag <= 1'b0;
      row_last <= 1'b0;
      done     <= 1'b0;
    end else begin
      row_flag <= tap.valid && tap.last_i;
      row_last <= tap.valid && tap.last;
      done     <= row_flag && row_last;
    end
    if (tap.valid) begin
      h_acc <= (tap.i == 2'd0) ? 37'(prod) : h_acc + 37'(prod);
      row_j <= tap.j;
    end
    if (row_flag) begin
      sum <= (row_j == 2'd0) ? 64'(row_prod) : sum + 64'(row_prod);
    end
  end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Image scaler testbench
// Loads small grey frames, emits output pixels in bilinear and bicubic mode
// across many size and clamp settings, and checks every output pixel and its
// row and frame flags against a cycle-free scaler predictor or fixed values.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 600;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_EMIT} row_kind_t;

  typedef struct {
    logic [15:0] pix;
    logic        eor;
    logic        eof;
  } px_result_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [15:0] val;
    bit          typed;
    px_result_t  want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = imrs_pkg::MODE_LOAD;
  logic [15:0] pixel_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] pixel_out;
  logic        end_of_row;
  logic        end_of_frame;

  image_resize_bilinear_bicubic i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Scaler state as the predictor sees it.
  logic [15:0] frame_mem [65536];
  logic [8:0]  r_iw, r_ih;
  logic [12:0] r_ow, r_oh;
  logic [15:0] r_max;
  logic        r_filter;
  int          load_pos, col_pos, row_pos;

  px_result_t  expected_pixels[$];
  int          errors, cycles, n_loads, n_emits, n_checked, n_phases;
  bit          quiet, cfg_active;

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint frame_tap(int x, int y);
    int w, h;
    w = clampi(r_iw, 4, 256);
    h = clampi(r_ih, 4, 256);
    x = clampi(x, 0, w - 1);
    y = clampi(y, 0, h - 1);
    return longint'(frame_mem[y * w + x]);
  endfunction

  function automatic longint cr_weight(int k, longint u);
    longint t1, t2, t3, n;
    t1 = u <<< 32;
    t2 = (u * u) <<< 16;
    t3 = u * u * u;
    case (k)
      0: n = -t3 + 2 * t2 - t1;
      1: n = 3 * t3 - 5 * t2 + (64'sd1 <<< 49);
      2: n = -3 * t3 + 4 * t2 + t1;
      default: n = t3 - t2;
    endcase
    return (n + (64'sd1 <<< 32)) >>> 33;
  endfunction

  function automatic logic [15:0] saturate_q32(longint s);
    longint q;
    if (s <= 0) return 16'd0;
    q = s >>> 32;
    return q > longint'(r_max) ? r_max : q[15:0];
  endfunction

  function automatic logic [15:0] scaled_pixel(longint px, longint py);
    int ix, iy;
    longint fx, fy, h0, h1, hs, sum;
    ix = int'(px >>> 16);
    iy = int'(py >>> 16);
    fx = px & 64'hFFFF;
    fy = py & 64'hFFFF;
    if (r_filter == imrs_pkg::FILTER_BILINEAR) begin
      if (ix == clampi(r_iw, 4, 256) - 1) begin
        ix -= 1;
        fx += 65536;
      end
      if (iy == clampi(r_ih, 4, 256) - 1) begin
        iy -= 1;
        fy += 65536;
      end
      h0 = frame_tap(ix, iy) * (65536 - fx) + frame_tap(ix + 1, iy) * fx;
      h1 = frame_tap(ix, iy + 1) * (65536 - fx) + frame_tap(ix + 1, iy + 1) * fx;
      return saturate_q32(h0 * (65536 - fy) + h1 * fy);
    end
    sum = 0;
    for (int j = 0; j < 4; j++) begin
      hs = 0;
      for (int i = 0; i < 4; i++)
        hs += cr_weight(i, fx) * frame_tap(ix - 1 + i, iy - 1 + j);
      sum += cr_weight(j, fy) * hs;
    end
    return saturate_q32(sum);
  endfunction

  function automatic px_result_t predict_item(logic m, logic [15:0] p);
    px_result_t res;
    int iw, ih, ow, oh;
    longint px, py;
    iw = clampi(r_iw, 4, 256);
    ih = clampi(r_ih, 4, 256);
    ow = clampi(r_ow, 1, 4096);
    oh = clampi(r_oh, 1, 4096);
    res = '{16'd0, 1'b0, 1'b0};
    if (m == imrs_pkg::MODE_LOAD) begin
      if (load_pos >= iw * ih) load_pos = 0;
      frame_mem[load_pos] = p;
      load_pos++;
      if (load_pos >= iw * ih) load_pos = 0;
      return res;
    end
    if (col_pos >= ow) col_pos = 0;
    if (row_pos >= oh) row_pos = 0;
    px = (longint'(col_pos) * iw <<< 16) / ow;
    py = (longint'(row_pos) * ih <<< 16) / oh;
    res.pix = scaled_pixel(px, py);
    res.eor = (col_pos == ow - 1);
    res.eof = res.eor && (row_pos == oh - 1);
    if (res.eor) begin
      col_pos = 0;
      row_pos = res.eof ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      imrs_pkg::REG_IN_WIDTH:    r_iw = val[8:0];
      imrs_pkg::REG_IN_HEIGHT:   r_ih = val[8:0];
      imrs_pkg::REG_OUT_WIDTH:   r_ow = val[12:0];
      imrs_pkg::REG_OUT_HEIGHT:  r_oh = val[12:0];
      imrs_pkg::REG_MAX_VALUE:   r_max = val;
      imrs_pkg::REG_FILTER_KIND: r_filter = val[0];
      default:                   return;
    endcase
    load_pos = 0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  task automatic mismatch_report(string msg);
    $display("mismatch @%0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [15:0] val);
    if (!cfg_active) wait_idle();
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    apply_reg(idx, val);
    cfg_active = 1'b1;
  endtask

  task automatic cfg_close();
    if (cfg_active) cfg_write_en <= 1'b0;
    cfg_active = 1'b0;
  endtask

  task automatic send_item(logic m, logic [15:0] p, bit typed, px_result_t want);
    px_result_t res;
    int gap;
    cfg_close();
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    pixel_in <= p;
    do @(posedge clk); while (!in_ready);
    res = predict_item(m, p);
    if (m == imrs_pkg::MODE_EMIT) begin
      expected_pixels.push_back(typed ? want : res);
      n_emits++;
    end else begin
      n_loads++;
    end
  endtask

  function automatic logic [15:0] pick_pixel(int style, int k);
    case (style)
      0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1: return 16'(k * 997);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [12:0] pick_out_dim();
    case ($urandom_range(0, 15))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'd8191;
      3: return 13'($urandom());
      default: return 13'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [8:0] pick_in_dim();
    case ($urandom_range(0, 19))
      0: return 9'($urandom_range(0, 3));
      1: return 9'd256;
      2: return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(4, 12));
    endcase
  endfunction

  // Receiving side with random stall bursts.
  initial begin
    int stall;
    px_result_t exp_px;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatch_report($sformatf("unexpected output pixel %0d", pixel_out));
        end else begin
          exp_px = expected_pixels.pop_front();
          n_checked++;
          if (pixel_out !== exp_px.pix)
            mismatch_report($sformatf("pixel_out %0d, expected %0d", pixel_out, exp_px.pix));
          if (end_of_row !== exp_px.eor)
            mismatch_report($sformatf("end_of_row %0b, expected %0b", end_of_row, exp_px.eor));
          if (end_of_frame !== exp_px.eof)
            mismatch_report($sformatf("end_of_frame %0b, expected %0b", end_of_frame,
                                      exp_px.eof));
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!quiet && !rst && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t stim_rows[$];
    px_result_t none;
    int items, iw, ih, style, n_emit;
    none = '{16'd0, 1'b0, 1'b0};
    r_iw = 9'd256;
    r_ih = 9'd256;
    r_ow = 13'd256;
    r_oh = 13'd256;
    r_max = 16'hFFFF;
    r_filter = imrs_pkg::FILTER_BICUBIC;
    load_pos = 0;
    col_pos = 0;
    row_pos = 0;

    stim_rows.push_back('{ROW_CFG, imrs_pkg::REG_IN_WIDTH, 16'd4, 0, none});
    stim_rows.push_back('{ROW_CFG, imrs_pkg::REG_IN_HEIGHT, 16'd4, 0, none});
    stim_rows.push_back('{ROW_CFG, imrs_pkg::REG_OUT_WIDTH, 16'd1, 0, none});
    stim_rows.push_back('{ROW_CFG, imrs_pkg::REG_OUT_HEIGHT, 16'd1, 0, none});
    stim_rows.push_back('{ROW_CFG, imrs_pkg::REG_MAX_VALUE, 16'hFFFF, 0, none});
    stim_rows.push_back('{ROW_CFG, imrs_pkg::REG_FILTER_KIND,
                          16'(imrs_pkg::FILTER_BILINEAR), 0, none});
    stim_rows.push_back('{ROW_LOAD, 3'd0, 16'hFFFF, 0, none});
    stim_rows.push_back('{ROW_LOAD, 3'd0, 16'h0000, 0, none});
    for (int k = 2; k < 16; k++)
      stim_rows.push_back('{ROW_LOAD, 3'd0, 16'(k * 4681), 0, none});
    stim_rows.push_back('{ROW_EMIT, 3'd0, 16'd0, 1, '{16'hFFFF, 1'b1, 1'b1}});
    stim_rows.push_back('{ROW_EMIT, 3'd0, 16'd0, 1, '{16'hFFFF, 1'b1, 1'b1}});
    // A load past the end of the frame wraps to the first pixel.
    stim_rows.push_back('{ROW_LOAD, 3'd0, 16'd7, 0, none});
    stim_rows.push_back('{ROW_EMIT, 3'd0, 16'd0, 1, '{16'd7, 1'b1, 1'b1}});
    stim_rows.push_back('{ROW_CFG, imrs_pkg::REG_MAX_VALUE, 16'd0, 0, none});
    stim_rows.push_back('{ROW_EMIT, 3'd0, 16'd0, 1, '{16'd0, 1'b1, 1'b1}});
    stim_rows.push_back('{ROW_CFG, imrs_pkg::REG_MAX_VALUE, 16'd5, 0, none});
    stim_rows.push_back('{ROW_EMIT, 3'd0, 16'd0, 1, '{16'd5, 1'b1, 1'b1}});
    stim_rows.push_back('{ROW_CFG, imrs_pkg::REG_MAX_VALUE, 16'hFFFF, 0, none});
    stim_rows.push_back('{ROW_CFG, imrs_pkg::REG_FILTER_KIND,
                          16'(imrs_pkg::FILTER_BICUBIC), 0, none});
    stim_rows.push_back('{ROW_EMIT, 3'd0, 16'd0, 1, '{16'd7, 1'b1, 1'b1}});
    stim_rows.push_back('{ROW_CFG, imrs_pkg::REG_OUT_WIDTH, 16'd2, 0, none});
    stim_rows.push_back('{ROW_CFG, REG_UNUSED, 16'hFFFF, 0, none});
    stim_rows.push_back('{ROW_EMIT, 3'd0, 16'd0, 0, none});
    stim_rows.push_back('{ROW_EMIT, 3'd0, 16'd0, 0, none});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[r]) begin
      case (stim_rows[r].kind)
        ROW_CFG:  reg_write(stim_rows[r].idx, stim_rows[r].val);
        ROW_LOAD: send_item(imrs_pkg::MODE_LOAD, stim_rows[r].val, 0, none);
        default:  send_item(imrs_pkg::MODE_EMIT, 16'd0, stim_rows[r].typed,
                            stim_rows[r].want);
      endcase
    end

    items = 0;
    while (items < RANDOM_ITEMS) begin
      n_phases++;
      iw = clampi(pick_in_dim(), 4, 256);
      reg_write(imrs_pkg::REG_IN_WIDTH, 16'(pick_in_dim()));
      iw = clampi(r_iw, 4, 256);
      reg_write(imrs_pkg::REG_IN_HEIGHT, 16'(pick_in_dim()));
      if (iw * clampi(r_ih, 4, 256) > 1100) reg_write(imrs_pkg::REG_IN_HEIGHT, 16'd4);
      ih = clampi(r_ih, 4, 256);
      if (items + iw * ih > RANDOM_ITEMS + 40) begin
        reg_write(imrs_pkg::REG_IN_WIDTH, 16'd4);
        reg_write(imrs_pkg::REG_IN_HEIGHT, 16'd4);
        iw = 4;
        ih = 4;
      end
      reg_write(imrs_pkg::REG_OUT_WIDTH, 16'(pick_out_dim()));
      reg_write(imrs_pkg::REG_OUT_HEIGHT, 16'(pick_out_dim()));
      case ($urandom_range(0, 7))
        0: reg_write(imrs_pkg::REG_MAX_VALUE, 16'd0);
        1: reg_write(imrs_pkg::REG_MAX_VALUE, 16'($urandom_range(1, 255)));
        2: reg_write(imrs_pkg::REG_MAX_VALUE, 16'($urandom()));
        default: reg_write(imrs_pkg::REG_MAX_VALUE, 16'hFFFF);
      endcase
      reg_write(imrs_pkg::REG_FILTER_KIND, 16'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) reg_write(3'($urandom_range(6, 7)), 16'($urandom()));
      style = $urandom_range(0, 3);
      for (int k = 0; k < iw * ih; k++) begin
        send_item(imrs_pkg::MODE_LOAD, pick_pixel(style, k), 0, none);
        items++;
      end
      n_emit = $urandom_range(4, 40);
      for (int k = 0; k < n_emit; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item(imrs_pkg::MODE_LOAD, 16'($urandom()), 0, none);
          items++;
        end
        send_item(imrs_pkg::MODE_EMIT, 16'($urandom()), 0, none);
        items++;
        quiet = (items > RANDOM_ITEMS * 85 / 100);
      end
    end

    cfg_close();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (expected_pixels.size() != 0)
      mismatch_report($sformatf("%0d output pixels never arrived", expected_pixels.size()));
    $display("Covered %0d setting phases: %0d pixels loaded, %0d emitted, %0d checked.",
             n_phases, n_loads, n_emits, n_checked);
    $display("Both filters, clamped sizes, saturation and frame wraps were exercised.");
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
